// ===== design/ssa_pkg.sv =====
package ssa_pkg;

  localparam int IMAGE_ROWS = 512;
  localparam int IMAGE_COLS = 1024;

  localparam int ROW_AW = $clog2(IMAGE_ROWS);
  localparam int X_W = 10;
  localparam int ROW_W = 9;
  localparam int OP_W = 2;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [X_W-1:0]   point_x;
    logic [ROW_W-1:0] row_index;
  } span_req_t;

  typedef struct packed {
    logic           row_seen;
    logic [X_W-1:0] span_min;
    logic [X_W-1:0] span_max;
    logic           has_interior;
  } span_rsp_t;

  typedef struct packed {
    logic           seen;
    logic [X_W-1:0] lo;
    logic [X_W-1:0] hi;
  } span_entry_t;

  localparam int ENTRY_W = $bits(span_entry_t);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_CLEAR
  } ssa_state_t;

endpackage

// ===== design/ssa_ram.sv =====
module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/ssa_update.sv =====
module ssa_update (
  input  ssa_pkg::span_req_t   req,
  input  ssa_pkg::span_entry_t cur,
  output ssa_pkg::span_entry_t upd,
  output logic                 upd_we,
  output ssa_pkg::span_rsp_t   rsp
);
  import ssa_pkg::*;

  logic           row_ok;
  logic           col_ok;
  logic [X_W:0]   diff;

  always_comb begin
    row_ok = 32'(req.row_index) < IMAGE_ROWS;
    col_ok = 32'(req.point_x) < IMAGE_COLS;
    upd = cur;
    upd_we = 1'b0;
    if (req.operation == OP_ADD && row_ok && col_ok) begin
      upd_we = 1'b1;
      if (!cur.seen) begin
        upd.seen = 1'b1;
        upd.lo = req.point_x;
        upd.hi = req.point_x;
      end else begin
        if (req.point_x < cur.lo) begin
          upd.lo = req.point_x;
        end
        if (req.point_x > cur.hi) begin
          upd.hi = req.point_x;
        end
      end
    end

    diff = {1'b0, upd.hi} - {1'b0, upd.lo};
    rsp = '0;
    if (req.operation != OP_CLEAR && row_ok && upd.seen) begin
      rsp.row_seen = 1'b1;
      rsp.span_min = upd.lo;
      rsp.span_max = upd.hi;
      rsp.has_interior = !diff[X_W] && (diff[X_W-1:0] >= X_W'(2));
    end
  end

endmodule

// ===== design/scanline_span_accumulator.sv =====
// Channel  Direction  Payload      Handshake
// in       input      span_req_t   in_valid / in_stall
// out      output     span_rsp_t   out_valid / out_stall
//
// An add or read request first reads the row entry, then updates it and loads the
// result register. A clear request writes every row entry of the span memory once
// before its result is loaded into the result register.
// After reset the block runs the same pass over IMAGE_ROWS entries before it
// takes its first request. A stalled result waits in the output register while
// the next request is read; the update then waits until that register is free.
module scanline_span_accumulator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ssa_pkg::span_req_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ssa_pkg::span_rsp_t out_data
);
  import ssa_pkg::*;

  ssa_state_t        state_r, state_nxt;
  logic [ROW_AW-1:0] cnt_r, cnt_nxt;
  span_req_t         req_r, req_nxt;
  logic              out_valid_r, out_valid_nxt;
  span_rsp_t         out_data_r, out_data_nxt;

  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ENTRY_W-1:0] ram_rdata;

  span_entry_t       cur;
  span_entry_t       upd;
  logic              upd_we;
  span_rsp_t         rsp;
  logic              accept;
  logic              out_free;
  logic              sweep_last;

  ssa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(IMAGE_ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_data.row_index[ROW_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign cur = span_entry_t'(ram_rdata);

  ssa_update u_update (
    .req    (req_r),
    .cur    (cur),
    .upd    (upd),
    .upd_we (upd_we),
    .rsp    (rsp)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign ram_re = accept;
  assign out_free = !out_valid_r || !out_stall;
  assign sweep_last = (cnt_r == ROW_AW'(IMAGE_ROWS - 1));
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    req_nxt = req_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    ram_we = 1'b0;
    ram_waddr = cnt_r;
    ram_wdata = '0;
    unique case (state_r)
      ST_INIT: begin
        ram_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (sweep_last) begin
          cnt_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          if (in_data.operation == OP_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (sweep_last) begin
          cnt_nxt = '0;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          ram_we = upd_we;
          ram_waddr = req_r.row_index[ROW_AW-1:0];
          ram_wdata = ENTRY_W'(upd);
          out_valid_nxt = 1'b1;
          out_data_nxt = rsp;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== tb/span_checker.sv =====
`timescale 1ns / 1ps

module span_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ssa_pkg::span_req_t in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ssa_pkg::span_rsp_t out_data,
  output int unsigned        outstanding,
  output int unsigned        fail_count
);
  import ssa_pkg::*;

  bit             row_seen_tbl [IMAGE_ROWS];
  logic [X_W-1:0] row_lo_tbl   [IMAGE_ROWS];
  logic [X_W-1:0] row_hi_tbl   [IMAGE_ROWS];
  span_rsp_t      expected_spans [$];
  span_rsp_t      want;
  int unsigned    mismatches;

  initial begin
    outstanding = 0;
    fail_count  = 0;
    mismatches  = 0;
    foreach (row_seen_tbl[i]) begin
      row_seen_tbl[i] = 1'b0;
      row_lo_tbl[i]   = '0;
      row_hi_tbl[i]   = '0;
    end
  end

  function automatic span_rsp_t next_span_rsp(span_req_t req);
    span_rsp_t   rsp;
    int unsigned row;
    rsp = '0;
    row = 32'(req.row_index);
    if (req.operation == OP_CLEAR) begin
      foreach (row_seen_tbl[i]) row_seen_tbl[i] = 1'b0;
      return rsp;
    end
    if (req.operation == OP_ADD && row < IMAGE_ROWS && req.point_x < IMAGE_COLS) begin
      if (!row_seen_tbl[row]) begin
        row_seen_tbl[row] = 1'b1;
        row_lo_tbl[row]   = req.point_x;
        row_hi_tbl[row]   = req.point_x;
      end else begin
        if (req.point_x < row_lo_tbl[row]) row_lo_tbl[row] = req.point_x;
        if (req.point_x > row_hi_tbl[row]) row_hi_tbl[row] = req.point_x;
      end
    end
    if (row < IMAGE_ROWS && row_seen_tbl[row]) begin
      rsp.row_seen     = 1'b1;
      rsp.span_min     = row_lo_tbl[row];
      rsp.span_max     = row_hi_tbl[row];
      rsp.has_interior = (row_hi_tbl[row] >= row_lo_tbl[row]) &&
                         (row_hi_tbl[row] - row_lo_tbl[row] >= 2);
    end
    return rsp;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_spans.size() == 0) begin
          $display("%0t: unexpected result seen=%0b min=%0d max=%0d interior=%0b",
                   $time, out_data.row_seen, out_data.span_min, out_data.span_max,
                   out_data.has_interior);
          mismatches++;
        end else begin
          want = expected_spans.pop_front();
          if (out_data !== want) begin
            $display("%0t: expected seen=%0b min=%0d max=%0d interior=%0b",
                     $time, want.row_seen, want.span_min, want.span_max,
                     want.has_interior);
            $display("%0t: actual   seen=%0b min=%0d max=%0d interior=%0b",
                     $time, out_data.row_seen, out_data.span_min, out_data.span_max,
                     out_data.has_interior);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_spans.push_back(next_span_rsp(in_data));
      end
    end
    outstanding <= expected_spans.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== tb/tb_scanline_span_accumulator.sv =====
`timescale 1ns / 1ps

module tb_scanline_span_accumulator;
  import ssa_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_ITEMS   = 1880;
  localparam int RX_HOLD_CYCLES = 100;
  localparam int DRAIN_CYCLES   = 20;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  span_req_t   in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  span_rsp_t   out_data;
  int unsigned outstanding;
  int unsigned fail_count;

  bit          tx_idle_on  = 1'b1;
  bit          rx_idle_on  = 1'b1;
  bit          rx_hold_now = 1'b0;
  int unsigned pool_row [8];
  int unsigned pool_x   [8];

  scanline_span_accumulator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  span_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Each request is held until the block takes it, then an optional gap follows.
  task automatic send_span_req(logic [OP_W-1:0] op, logic [X_W-1:0] x,
                               logic [ROW_W-1:0] row);
    in_valid          <= 1'b1;
    in_data.operation <= op;
    in_data.point_x   <= x;
    in_data.row_index <= row;
    do @(posedge clk); while (in_stall);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_spans_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_now) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        out_stall   <= 1'b0;
        rx_hold_now = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned      sel;
    int unsigned      slot;
    logic [OP_W-1:0]  op;
    logic [X_W-1:0]   x;
    logic [ROW_W-1:0] row;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_span_req(OP_READ,  10'd0,    9'd0);
    send_span_req(OP_ADD,   10'd5,    9'd0);
    send_span_req(OP_ADD,   10'd6,    9'd0);
    send_span_req(OP_ADD,   10'd7,    9'd0);
    send_span_req(OP_ADD,   10'd3,    9'd0);
    send_span_req(OP_ADD,   10'd5,    9'd0);
    send_span_req(OP_READ,  10'd1023, 9'd0);
    send_span_req(OP_SPARE, 10'd0,    9'd0);
    send_span_req(OP_SPARE, 10'd1023, 9'd511);
    send_span_req(OP_ADD,   10'd1023, 9'd511);
    send_span_req(OP_ADD,   10'd0,    9'd511);
    send_span_req(OP_READ,  10'd0,    9'd511);
    send_span_req(OP_ADD,   10'd0,    9'd1);
    send_span_req(OP_ADD,   10'd1,    9'd1);
    send_span_req(OP_READ,  10'd0,    9'd1);
    send_span_req(OP_ADD,   10'd512,  9'd256);
    send_span_req(OP_ADD,   10'd511,  9'd256);
    send_span_req(OP_CLEAR, 10'd1023, 9'd511);
    send_span_req(OP_READ,  10'd0,    9'd0);
    send_span_req(OP_READ,  10'd0,    9'd511);
    send_span_req(OP_ADD,   10'd9,    9'd0);
    send_span_req(OP_READ,  10'd0,    9'd0);
    send_span_req(OP_CLEAR, 10'd0,    9'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        foreach (pool_row[i]) begin
          pool_row[i] = $urandom_range(0, IMAGE_ROWS - 1);
          pool_x[i]   = $urandom_range(0, IMAGE_COLS - 1);
        end
        pool_row[0] = 0;
        pool_row[1] = IMAGE_ROWS - 1;
      end
      if (n == 400) rx_hold_now = 1'b1;
      if (n == 800) wait_spans_drained();
      tx_idle_on = !(n >= 900 && n < 1100) && (n < RANDOM_ITEMS - 300);
      rx_idle_on = tx_idle_on;

      sel  = $urandom_range(0, 199);
      slot = $urandom_range(0, 7);
      if (sel == 0) op = OP_CLEAR;
      else if (sel <= 10) op = OP_SPARE;
      else if (sel <= 80) op = OP_READ;
      else op = OP_ADD;
      if ($urandom_range(0, 4) == 0) row = ROW_W'($urandom_range(0, IMAGE_ROWS - 1));
      else row = ROW_W'(pool_row[slot]);
      if (op == OP_ADD && $urandom_range(0, 4) >= 2) begin
        x = X_W'(pool_x[slot] + $urandom_range(0, 3));
      end else begin
        x = X_W'($urandom_range(0, IMAGE_COLS - 1));
      end
      send_span_req(op, x, row);
    end

    wait_spans_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
